// ===== src/rxs_pkg.sv =====
// Shared types and constants for the record exchange sort block.
package rxs_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int NAME_CHARS  = 8;

    localparam int NAME_W  = 64;
    localparam int GRADE_W = 10;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = $clog2(MAX_RECORDS);
    localparam int CNT_W   = $clog2(MAX_RECORDS + 1);

    localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(1000);

    // Keep the top NAME_CHARS bytes of a name, clear the rest.
    localparam logic [NAME_W-1:0] NAME_MASK = ~({NAME_W{1'b1}} >> (8 * NAME_CHARS));

    localparam logic [MODE_W-1:0] MODE_ARRIVAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NAME    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRADE   = 2'd2;

    typedef struct packed {
        logic [NAME_W-1:0]  student_name;
        logic [GRADE_W-1:0] grade;
        logic               last_record;
    } in_beat_t;

    typedef struct packed {
        logic [NAME_W-1:0]  sorted_name;
        logic [GRADE_W-1:0] sorted_grade;
        logic               last_result;
    } out_beat_t;

    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [GRADE_W-1:0] grade;
    } rec_t;

endpackage

// ===== src/record_exchange_sort_top.sv =====
// Record exchange sort: collects records in a memory, sorts them in place, streams them out.
// Usage:
//   s_valid/s_ready/s_data carry input beats (name, grade, last_record). Each
//   accepted beat is written to the record memory, one beat per cycle, up to
//   MAX_RECORDS records; further beats are dropped, but a dropped beat marked
//   last still closes the set. The beat marked last starts the sort and drain.
//   cfg_wr_en/cfg_wr_data set sort_mode: 0 or 3 keep arrival order, 1 sort by
//   name (unsigned 64-bit compare), 2 sort by grade. Write it only while idle.
//   m_valid/m_ready/m_data carry one result beat per stored record, in sorted
//   order, with last_result set on the final beat of the run.
// Timing:
//   The sort keeps position i in a register and walks j over the later entries,
//   one compare per cycle through the memory's single read port; arrival mode
//   skips it. Draining steps through read, load and handshake for each beat.
//   s_ready is high only while loading; it drops from the last input beat until
//   the last result beat has been taken.
// Reset and stalls: aresetn (synchronous, active low) empties the set, clears
//   sort_mode to 0 and drops any pending result; memory contents are kept. While
//   m_ready is low the result beat holds in the output register and the drain waits.
module record_exchange_sort_top (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  rxs_pkg::in_beat_t       s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output rxs_pkg::out_beat_t      m_data,
    input  logic                    cfg_wr_en,
    input  logic [rxs_pkg::MODE_W-1:0] cfg_wr_data
);
    import rxs_pkg::*;

    localparam logic [2:0] ST_LOAD    = 3'd0;
    localparam logic [2:0] ST_SORT_RD = 3'd1;
    localparam logic [2:0] ST_SORT_LD = 3'd2;
    localparam logic [2:0] ST_SORT_CP = 3'd3;
    localparam logic [2:0] ST_SORT_WB = 3'd4;
    localparam logic [2:0] ST_OUT_RD  = 3'd5;
    localparam logic [2:0] ST_OUT_LD  = 3'd6;
    localparam logic [2:0] ST_OUT_WT  = 3'd7;

    // Record memory: one write port, one registered read port.
    rec_t               mem [MAX_RECORDS];
    rec_t               rdata_reg;
    logic [IDX_W-1:0]   raddr;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    rec_t               wdata;

    logic [2:0]         state_reg, state_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    rec_t               cur_reg, cur_next;
    logic               m_valid_reg, m_valid_next;
    out_beat_t          out_reg, out_next;

    logic               s_fire, m_fire;
    logic               sorting;
    logic               swap;
    rec_t               in_rec;
    logic [CNT_W-1:0]   n_load;

    assign s_ready = (state_reg == ST_LOAD);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign m_fire  = m_valid_reg && m_ready;

    assign sorting = (mode_reg == MODE_NAME) || (mode_reg == MODE_GRADE);

    // Mask the name and saturate the grade on the way in.
    always_comb begin
        in_rec.name  = s_data.student_name & NAME_MASK;
        in_rec.grade = (s_data.grade > GRADE_MAX) ? GRADE_MAX : s_data.grade;
    end

    // Swap when the held record's key is larger than the one just read.
    always_comb begin
        if (mode_reg == MODE_NAME) begin
            swap = cur_reg.name > rdata_reg.name;
        end else begin
            swap = cur_reg.grade > rdata_reg.grade;
        end
    end

    assign n_load = (count_reg < CNT_W'(MAX_RECORDS)) ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        raddr        = '0;
        we           = 1'b0;
        waddr        = count_reg[IDX_W-1:0];
        wdata        = in_rec;

        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    // Drop the record when the memory is full.
                    if (count_reg < CNT_W'(MAX_RECORDS)) begin
                        we = 1'b1;
                    end
                    count_next = n_load;
                    if (s_data.last_record) begin
                        n_next     = n_load;
                        count_next = '0;
                        i_next     = '0;
                        k_next     = '0;
                        if (sorting && (n_load > CNT_W'(1))) begin
                            state_next = ST_SORT_RD;
                        end else begin
                            state_next = ST_OUT_RD;
                        end
                    end
                end
            end
            ST_SORT_RD: begin
                raddr      = i_reg[IDX_W-1:0];
                state_next = ST_SORT_LD;
            end
            ST_SORT_LD: begin
                // Hold position i in a register; start j one past it.
                cur_next   = rdata_reg;
                j_next     = i_reg + CNT_W'(1);
                raddr      = j_next[IDX_W-1:0];
                state_next = ST_SORT_CP;
            end
            ST_SORT_CP: begin
                if (swap) begin
                    we       = 1'b1;
                    waddr    = j_reg[IDX_W-1:0];
                    wdata    = cur_reg;
                    cur_next = rdata_reg;
                end
                if ((j_reg + CNT_W'(1)) < n_reg) begin
                    j_next = j_reg + CNT_W'(1);
                    raddr  = j_next[IDX_W-1:0];
                end else begin
                    state_next = ST_SORT_WB;
                end
            end
            ST_SORT_WB: begin
                // Write back position i and fetch the next one in the same cycle.
                we    = 1'b1;
                waddr = i_reg[IDX_W-1:0];
                wdata = cur_reg;
                if ((i_reg + CNT_W'(2)) < n_reg) begin
                    i_next     = i_reg + CNT_W'(1);
                    raddr      = i_next[IDX_W-1:0];
                    state_next = ST_SORT_LD;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                raddr      = k_reg[IDX_W-1:0];
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                out_next.sorted_name  = rdata_reg.name;
                out_next.sorted_grade = rdata_reg.grade;
                out_next.last_result  = (k_reg + CNT_W'(1)) == n_reg;
                m_valid_next          = 1'b1;
                state_next            = ST_OUT_WT;
            end
            ST_OUT_WT: begin
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    if (out_reg.last_result) begin
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            mode_reg    <= MODE_ARRIVAL;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("record count exceeds memory depth");

    a_valid_only_draining: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_OUT_WT))
        else $error("result valid outside drain wait");

    a_scan_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SORT_CP) |-> ((j_reg > i_reg) && (j_reg < n_reg)))
        else $error("compare index outside the pass");

    a_run_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && out_reg.last_result) |=> ((state_reg == ST_LOAD) && (count_reg == '0)))
        else $error("run did not return to an empty load");

    a_set_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last_record) |=> (!s_ready && (n_reg != '0)))
        else $error("last record did not close a non-empty set");

endmodule
